[src/fcull_pkg.sv]
// ----------------------------------------------------------------------------
// fcull_pkg
// Types and constants shared by the frustum cull test block.
// ----------------------------------------------------------------------------
package fcull_pkg;

    // Number of planes tested, one cell each (range 1 to 8)
    localparam int PLANE_COUNT = 6;
    // Number of writable plane registers
    localparam int REG_COUNT   = 6;

    localparam int COORD_W = 16;
    localparam int RAD_W   = 15;
    localparam int PROD_W  = 2 * COORD_W;
    // Q1.14 fraction bits: w and radius are moved up by this to line up
    localparam int FRAC_SH = 14;
    // Three products, the scaled w and the scaled radius, plus three bits of headroom
    localparam int SUM_W   = PROD_W + 3;
    localparam int PLANE_W = 64;
    localparam int IDX_W   = 3;

    // operation codes
    localparam logic OP_SPHERE = 1'b0;
    localparam logic OP_BOX    = 1'b1;

    // Field offsets inside a plane register
    localparam int NX_LSB = 0;
    localparam int NY_LSB = 16;
    localparam int NZ_LSB = 32;
    localparam int W_LSB  = 48;

    typedef struct packed {
        logic                      operation;
        logic signed [COORD_W-1:0] x_lo;
        logic signed [COORD_W-1:0] y_lo;
        logic signed [COORD_W-1:0] z_lo;
        logic signed [COORD_W-1:0] x_hi;
        logic signed [COORD_W-1:0] y_hi;
        logic signed [COORD_W-1:0] z_hi;
        logic        [RAD_W-1:0]   radius;
        logic                      batch_end;
    } t_in_item;

    typedef struct packed {
        logic visible;
        logic batch_end_out;
    } t_out_item;

    // Word travelling down the chain of cells
    typedef struct packed {
        t_in_item obj;
        logic     vis;
    } t_item;

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   index;
        logic [PLANE_W-1:0] data;
    } t_cfg_wr;

    // Occupancy of the two stages of one cell
    typedef struct packed {
        logic a_valid;
        logic b_valid;
    } t_cell_stat;

endpackage

[src/fcull_if.sv]
// ----------------------------------------------------------------------------
// fcull_if
// Handshake channels of the frustum cull test block.
// ----------------------------------------------------------------------------
interface fcull_in_if;
    logic                valid;
    logic                ready;
    fcull_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fcull_out_if;
    logic                 valid;
    logic                 ready;
    fcull_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fcull_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [fcull_pkg::IDX_W-1:0]         index;
    logic [fcull_pkg::PLANE_W-1:0]       data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/fcull_cell.sv]
// ----------------------------------------------------------------------------
// fcull_cell
// One plane of the test: holds the plane register, multiplies the chosen
// corner by the normal in stage A, sums and compares in stage B.
// ----------------------------------------------------------------------------
module fcull_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [fcull_pkg::IDX_W-1:0] i_cell_idx,
    input  fcull_pkg::t_cfg_wr          i_cfg,
    input  logic                        i_valid,
    input  fcull_pkg::t_item            i_item,
    output logic                        o_ready,
    output logic                        o_valid,
    output fcull_pkg::t_item            o_item,
    input  logic                        i_ready,
    output fcull_pkg::t_cell_stat       o_stat
);

    localparam int CW = fcull_pkg::COORD_W;
    localparam int PW = fcull_pkg::PROD_W;
    localparam int SW = fcull_pkg::SUM_W;
    localparam int FS = fcull_pkg::FRAC_SH;
    localparam int RW = fcull_pkg::RAD_W;

    localparam logic [fcull_pkg::IDX_W-1:0] IDX_W_REG =
        fcull_pkg::IDX_W'(fcull_pkg::REG_COUNT);

    logic [fcull_pkg::PLANE_W-1:0] r_plane;
    logic                          r_a_valid, n_a_valid;
    fcull_pkg::t_item              r_a_item;
    logic signed [PW-1:0]          r_a_prod [3];
    logic                          r_b_valid, n_b_valid;
    fcull_pkg::t_item              r_b_item;

    logic                          a_rdy, b_rdy, a_load, b_load, box, cull;
    logic signed [CW-1:0]          nx, ny, nz, pw;
    logic signed [CW-1:0]          cx, cy, cz;
    logic signed [PW-1:0]          n_prod [3];
    logic signed [SW-1:0]          plane_dist;
    logic        [SW-1:0]          rad_term;

    // Plane register; indexes past the register list never match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg.valid && (i_cfg.index == i_cell_idx) &&
                     (i_cell_idx < IDX_W_REG)) begin
            r_plane <= i_cfg.data;
        end
    end

    assign nx = r_plane[fcull_pkg::NX_LSB +: CW];
    assign ny = r_plane[fcull_pkg::NY_LSB +: CW];
    assign nz = r_plane[fcull_pkg::NZ_LSB +: CW];
    assign pw = r_plane[fcull_pkg::W_LSB  +: CW];

    // Handshake: each stage takes a word when empty or draining
    assign b_rdy   = !r_b_valid || i_ready;
    assign a_rdy   = !r_a_valid || b_rdy;
    assign a_load  = a_rdy && i_valid;
    assign b_load  = b_rdy && r_a_valid;
    assign o_ready = a_rdy;

    // Stage A: pick the corner furthest along the normal (box) or the centre (sphere), then multiply
    always_comb begin
        box = (i_item.obj.operation == fcull_pkg::OP_BOX);
        cx  = (box && !nx[CW-1]) ? i_item.obj.x_hi : i_item.obj.x_lo;
        cy  = (box && !ny[CW-1]) ? i_item.obj.y_hi : i_item.obj.y_lo;
        cz  = (box && !nz[CW-1]) ? i_item.obj.z_hi : i_item.obj.z_lo;
        n_prod[0] = nx * cx;
        n_prod[1] = ny * cy;
        n_prod[2] = nz * cz;
        n_a_valid = a_rdy ? i_valid : r_a_valid;
        n_b_valid = b_rdy ? r_a_valid : r_b_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_item <= i_item;
            r_a_prod <= n_prod;
        end
    end

    // Stage B: distance plus radius (sphere only) must not go negative
    always_comb begin
        rad_term = (r_a_item.obj.operation == fcull_pkg::OP_BOX) ? '0 :
                   {{(SW-RW-FS){1'b0}}, r_a_item.obj.radius, {FS{1'b0}}};
        plane_dist = {{(SW-PW){r_a_prod[0][PW-1]}}, r_a_prod[0]}
                   + {{(SW-PW){r_a_prod[1][PW-1]}}, r_a_prod[1]}
                   + {{(SW-PW){r_a_prod[2][PW-1]}}, r_a_prod[2]}
                   + {{(SW-CW-FS){pw[CW-1]}}, pw, {FS{1'b0}}}
                   + $signed(rad_term);
        cull = plane_dist[SW-1];
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b_item <= '{obj: r_a_item.obj, vis: r_a_item.vis && !cull};
        end
    end

    assign o_valid        = r_b_valid;
    assign o_item         = r_b_item;
    assign o_stat.a_valid = r_a_valid;
    assign o_stat.b_valid = r_b_valid;

endmodule

[src/frustum_cull_test.sv]
// ----------------------------------------------------------------------------
// frustum_cull_test
// Box and sphere visibility test against the stored frustum planes.
// ----------------------------------------------------------------------------
// Pipeline: a chain of PLANE_COUNT cells, two register stages per plane cell
// (multiply, then sum and compare).
// Throughput: one word per cycle while o_out is ready; each stage holds and
// moves on its own, so bubbles close up while a result waits at the output.
// Reset: all plane registers clear to zero and the pipeline empties; the
// configuration channel is always ready.
module frustum_cull_test (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fcull_in_if.sink           i_in,
    fcull_out_if.source        o_out,
    fcull_cfg_if.sink          i_cfg
);

    localparam int PC = fcull_pkg::PLANE_COUNT;

    logic                  chain_valid [PC+1];
    logic                  chain_ready [PC+1];
    fcull_pkg::t_item      chain_item  [PC+1];
    fcull_pkg::t_cell_stat stat        [PC];
    fcull_pkg::t_cfg_wr    cfg_wr;
    logic                  all_full;

    // Configuration writes go straight to the cells
    assign i_cfg.ready   = 1'b1;
    assign cfg_wr.valid  = i_cfg.valid;
    assign cfg_wr.index  = i_cfg.index;
    assign cfg_wr.data   = i_cfg.data;

    // Head of the chain: every object starts out visible
    assign chain_valid[0]    = i_in.valid;
    assign chain_item[0].obj = i_in.data;
    assign chain_item[0].vis = 1'b1;
    assign i_in.ready        = chain_ready[0];

    for (genvar g = 0; g < PC; g++) begin : g_cell
        fcull_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (fcull_pkg::IDX_W'(g)),
            .i_cfg      (cfg_wr),
            .i_valid    (chain_valid[g]),
            .i_item     (chain_item[g]),
            .o_ready    (chain_ready[g]),
            .o_valid    (chain_valid[g+1]),
            .o_item     (chain_item[g+1]),
            .i_ready    (chain_ready[g+1]),
            .o_stat     (stat[g])
        );
    end

    // Tail of the chain drives the result channel
    assign o_out.valid              = chain_valid[PC];
    assign o_out.data.visible       = chain_item[PC].vis;
    assign o_out.data.batch_end_out = chain_item[PC].obj.batch_end;
    assign chain_ready[PC]          = o_out.ready;

    always_comb begin
        all_full = 1'b1;
        for (int k = 0; k < PC; k++) begin
            all_full = all_full && stat[k].a_valid && stat[k].b_valid;
        end
    end

    // Checks
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid straight after reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (all_full && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while the chain is full and stalled");

    a_head_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !stat[0].a_valid |-> i_in.ready)
        else $error("input refused while the first stage is empty");

    a_head_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> stat[0].a_valid)
        else $error("accepted word did not reach the first stage");

endmodule

[bench/frustum_cull_test_test.sv]
// ----------------------------------------------------------------------------
// frustum_cull_test_test
// Self-checking bench for the frustum cull test block. A behavioural copy of
// the six plane registers predicts each visible flag exactly, in 64-bit
// arithmetic, for box and sphere words. Directed words cover touching,
// inverted boxes, field extremes and ignored spare register indexes. Random
// words then run over several plane settings with bursty gaps on both
// channels, a long output hold-off and a pause until the pipe drains.
// ----------------------------------------------------------------------------
module frustum_cull_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PIPE_LATENCY   = 2 * fcull_pkg::PLANE_COUNT;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam longint W_SCALE        = longint'(1) << fcull_pkg::FRAC_SH;

    // Plane register indexes; the top two are not backed by a register
    typedef enum logic [fcull_pkg::IDX_W-1:0] {
        PL_LEFT, PL_RIGHT, PL_BOTTOM, PL_TOP, PL_NEAR, PL_FAR, PL_SPARE6, PL_SPARE7
    } t_plane_idx;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fcull_in_if  in_ch ();
    fcull_out_if out_ch ();
    fcull_cfg_if cfg_ch ();

    frustum_cull_test i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow of the plane registers and the verdicts still owed by the block
    logic [fcull_pkg::PLANE_W-1:0] plane_regs [fcull_pkg::REG_COUNT] = '{default: '0};
    fcull_pkg::t_out_item          pending_verdicts [$];

    int  err_count     = 0;
    int  idle_cycles   = 0;
    int  n_box         = 0;
    int  n_sphere      = 0;
    int  n_visible     = 0;
    int  n_culled      = 0;
    int  n_settings    = 0;
    bit  src_gaps_on   = 1'b0;
    bit  sink_gaps_on  = 1'b0;
    bit  hold_req      = 1'b0;
    fcull_pkg::t_out_item got_word;
    fcull_pkg::t_out_item want_word;

    // Clock, 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic logic [fcull_pkg::PLANE_W-1:0] pack_plane(
        input shortint nx, input shortint ny, input shortint nz, input shortint w);
        return {w, nz, ny, nx};
    endfunction

    function automatic fcull_pkg::t_in_item mk_item(input logic op,
                                                    input shortint xl, input shortint yl,
                                                    input shortint zl, input shortint xh,
                                                    input shortint yh, input shortint zh,
                                                    input int rad, input logic be);
        fcull_pkg::t_in_item it;
        it.operation = op;
        it.x_lo      = xl;
        it.y_lo      = yl;
        it.z_lo      = zl;
        it.x_hi      = xh;
        it.y_hi      = yh;
        it.z_hi      = zh;
        it.radius    = rad[fcull_pkg::RAD_W-1:0];
        it.batch_end = be;
        return it;
    endfunction

    // Visible flag: box uses the corner furthest along each normal, sphere
    // compares the centre distance with minus the radius
    function automatic fcull_pkg::t_out_item predict_verdict(input fcull_pkg::t_in_item it);
        logic [fcull_pkg::PLANE_W-1:0] pw;
        longint                        lo [3];
        longint                        hi [3];
        longint                        plane_dist;
        longint                        n;
        longint                        c;
        longint                        rad;
        fcull_pkg::t_out_item          res;
        lo[0] = $signed(it.x_lo);
        lo[1] = $signed(it.y_lo);
        lo[2] = $signed(it.z_lo);
        hi[0] = $signed(it.x_hi);
        hi[1] = $signed(it.y_hi);
        hi[2] = $signed(it.z_hi);
        rad   = it.radius;
        res.visible       = 1'b1;
        res.batch_end_out = it.batch_end;
        for (int p = 0; p < fcull_pkg::PLANE_COUNT; p++) begin
            // planes beyond the register file are all zero and never cull
            pw   = (p < fcull_pkg::REG_COUNT) ? plane_regs[p] : '0;
            plane_dist = longint'($signed(pw[fcull_pkg::W_LSB +: 16])) * W_SCALE;
            for (int a = 0; a < 3; a++) begin
                n    = $signed(pw[16*a +: 16]);
                c    = (it.operation == fcull_pkg::OP_BOX && n >= 0) ? hi[a] : lo[a];
                plane_dist += n * c;
            end
            if (it.operation == fcull_pkg::OP_BOX) begin
                if (plane_dist < 0) res.visible = 1'b0;
            end else if (plane_dist < -(rad * W_SCALE)) begin
                res.visible = 1'b0;
            end
        end
        return res;
    endfunction

    // Monitor: shadow register writes, check results, predict on accept,
    // and watch for a stuck handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < fcull_pkg::REG_COUNT) begin
                plane_regs[cfg_ch.index] = cfg_ch.data;
            end
            if (out_ch.valid && out_ch.ready) begin
                got_word = out_ch.data;
                if (pending_verdicts.size() == 0) begin
                    report_error($sformatf("result word with nothing expected (visible=%0b)",
                                           got_word.visible));
                end else begin
                    want_word = pending_verdicts.pop_front();
                    if (got_word.visible !== want_word.visible)
                        report_error($sformatf("visible: expected %0b, got %0b",
                                               want_word.visible, got_word.visible));
                    if (got_word.batch_end_out !== want_word.batch_end_out)
                        report_error($sformatf("batch_end_out: expected %0b, got %0b",
                                               want_word.batch_end_out,
                                               got_word.batch_end_out));
                    if (want_word.visible) n_visible++;
                    else n_culled++;
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                pending_verdicts.push_back(predict_verdict(in_ch.data));
                if (in_ch.data.operation == fcull_pkg::OP_BOX) n_box++;
                else n_sphere++;
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, or one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (sink_gaps_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Drop valid and put noise on the data lines
    task automatic idle_input(input int n);
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        in_ch.data  = noise[$bits(fcull_pkg::t_in_item)-1:0];
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Offer one word and hold it until taken; valid stays high afterwards
    task automatic send_item(input fcull_pkg::t_in_item it);
        if (src_gaps_on && $urandom_range(0, 7) == 0) idle_input($urandom_range(1, 17));
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        idle_input(1);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_plane(input t_plane_idx idx,
                               input logic [fcull_pkg::PLANE_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic write_frustum(
        input logic [fcull_pkg::PLANE_W-1:0] pl [fcull_pkg::REG_COUNT]);
        for (int i = 0; i < fcull_pkg::REG_COUNT; i++) write_plane(t_plane_idx'(i), pl[i]);
        n_settings++;
    endtask

    function automatic shortint rand_coord(input bit wide);
        if (wide) return shortint'($urandom);
        return shortint'(int'($urandom_range(0, 8192)) - 4096);
    endfunction

    // Mostly ordered boxes and spheres near the origin; some full-range and inverted ones
    function automatic fcull_pkg::t_in_item rand_item();
        bit      wide;
        shortint a;
        shortint b;
        shortint lo [3];
        shortint hi [3];
        int      rad;
        wide = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < 3; k++) begin
            a = rand_coord(wide);
            b = rand_coord(wide);
            if ($urandom_range(0, 9) == 0 || a <= b) begin
                lo[k] = a;
                hi[k] = b;
            end else begin
                lo[k] = b;
                hi[k] = a;
            end
        end
        case ($urandom_range(0, 9))
            0:       rad = 0;
            1, 2:    rad = $urandom_range(0, 32767);
            default: rad = $urandom_range(0, 2000);
        endcase
        return mk_item(1'($urandom_range(0, 1)), lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                       rad, 1'($urandom_range(0, 1)));
    endfunction

    // A quarter fully random; the rest unit-ish normals, mostly with the origin inside
    function automatic logic [fcull_pkg::PLANE_W-1:0] rand_plane();
        if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
        return pack_plane(shortint'(int'($urandom_range(0, 32768)) - 16384),
                          shortint'(int'($urandom_range(0, 32768)) - 16384),
                          shortint'(int'($urandom_range(0, 32768)) - 16384),
                          shortint'(int'($urandom_range(0, 4500)) - 500));
    endfunction

    // ---- tests ----

    // All planes zero after reset: every distance is zero, nothing culls
    task automatic test_reset_planes();
        send_item(mk_item(fcull_pkg::OP_BOX, -32768, -32768, -32768,
                          32767, 32767, 32767, 0, 1'b0));
        send_item(mk_item(fcull_pkg::OP_BOX, 32767, 32767, 32767,
                          -32768, -32768, -32768, 32767, 1'b1));
        send_item(mk_item(fcull_pkg::OP_SPHERE, 32767, -32768, 0, 0, 0, 0, 0, 1'b1));
        wait_drained();
    endtask

    // Writes to the indexes past the register file must change nothing
    task automatic test_spare_index();
        write_plane(PL_SPARE6, pack_plane(0, 0, 0, -32768));
        write_plane(PL_SPARE7, pack_plane(-32768, -32768, -32768, -32768));
        send_item(mk_item(fcull_pkg::OP_BOX, 100, 200, 300, 400, 500, 600, 0, 1'b0));
        send_item(mk_item(fcull_pkg::OP_SPHERE, -5, 7, 9, 0, 0, 0, 0, 1'b1));
        wait_drained();
    endtask

    // Axis-aligned cube of half-width 100 units (1600 in Q11.4)
    task automatic test_directed_frustum();
        logic [fcull_pkg::PLANE_W-1:0] pl [fcull_pkg::REG_COUNT];
        pl[PL_LEFT]   = pack_plane(16384, 0, 0, 1600);
        pl[PL_RIGHT]  = pack_plane(-16384, 0, 0, 1600);
        pl[PL_BOTTOM] = pack_plane(0, 16384, 0, 1600);
        pl[PL_TOP]    = pack_plane(0, -16384, 0, 1600);
        pl[PL_NEAR]   = pack_plane(0, 0, 16384, 1600);
        pl[PL_FAR]    = pack_plane(0, 0, -16384, 1600);
        write_frustum(pl);
        // boxes: inside, outside, straddling, touching and just past
        send_item(mk_item(fcull_pkg::OP_BOX, -100, -100, -100, 100, 100, 100, 0, 1'b0));
        send_item(mk_item(fcull_pkg::OP_BOX, -3000, -100, -100, -2000, 100, 100, 0, 1'b1));
        send_item(mk_item(fcull_pkg::OP_BOX, -2000, -100, -100, 0, 100, 100, 0, 1'b0));
        send_item(mk_item(fcull_pkg::OP_BOX, -2000, 0, 0, -1600, 0, 0, 0, 1'b0));
        send_item(mk_item(fcull_pkg::OP_BOX, -2000, 0, 0, -1601, 0, 0, 0, 1'b1));
        send_item(mk_item(fcull_pkg::OP_BOX, 0, 0, 1601, 0, 0, 2000, 0, 1'b0));
        // inverted boxes: fields used as given
        send_item(mk_item(fcull_pkg::OP_BOX, 500, 0, 0, -3000, 0, 0, 0, 1'b0));
        send_item(mk_item(fcull_pkg::OP_BOX, 0, 3000, 0, 0, 0, 0, 0, 1'b1));
        send_item(mk_item(fcull_pkg::OP_BOX, 10, 10, 10, -10, -10, -10, 0, 1'b0));
        // points and spheres around the left and far planes
        send_item(mk_item(fcull_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_item(mk_item(fcull_pkg::OP_SPHERE, -1600, 0, 0, 0, 0, 0, 0, 1'b1));
        send_item(mk_item(fcull_pkg::OP_SPHERE, -1601, 0, 0, 0, 0, 0, 0, 1'b0));
        send_item(mk_item(fcull_pkg::OP_SPHERE, -2000, 0, 0, 0, 0, 0, 400, 1'b0));
        send_item(mk_item(fcull_pkg::OP_SPHERE, -2000, 0, 0, 0, 0, 0, 399, 1'b1));
        send_item(mk_item(fcull_pkg::OP_SPHERE, 0, 0, 2000, 0, 0, 0, 400, 1'b0));
        // field extremes; hi fields in sphere mode and radius in box mode ignored
        send_item(mk_item(fcull_pkg::OP_BOX, -32768, -32768, -32768,
                          32767, 32767, 32767, 32767, 1'b1));
        send_item(mk_item(fcull_pkg::OP_BOX, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767, 1'b0));
        send_item(mk_item(fcull_pkg::OP_SPHERE, -32768, -32768, -32768,
                          0, 0, 0, 32767, 1'b0));
        send_item(mk_item(fcull_pkg::OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 0, 1'b1));
        send_item(mk_item(fcull_pkg::OP_SPHERE, 0, 0, 0,
                          -32768, -32768, -32768, 0, 1'b1));
        wait_drained();
    endtask

    // Planes with every field at one extreme, random words
    task automatic test_extreme_planes();
        logic [fcull_pkg::PLANE_W-1:0] pl [fcull_pkg::REG_COUNT];
        for (int i = 0; i < fcull_pkg::REG_COUNT; i++)
            pl[i] = pack_plane(32767, 32767, 32767, 32767);
        write_frustum(pl);
        repeat (25) send_item(rand_item());
        wait_drained();
        for (int i = 0; i < fcull_pkg::REG_COUNT; i++)
            pl[i] = (i % 2) ? pack_plane(-32768, 32767, -32768, -32768)
                            : pack_plane(-32768, -32768, -32768, 32767);
        write_frustum(pl);
        repeat (25) send_item(rand_item());
        wait_drained();
    endtask

    // Random frusta, gaps switched per setting so some stretches run clean
    task automatic test_random_frusta();
        logic [fcull_pkg::PLANE_W-1:0] pl [fcull_pkg::REG_COUNT];
        for (int s = 0; s < 5; s++) begin
            for (int i = 0; i < fcull_pkg::REG_COUNT; i++) pl[i] = rand_plane();
            write_frustum(pl);
            if ($urandom_range(0, 1)) write_plane(t_plane_idx'($urandom_range(6, 7)),
                                                  {$urandom, $urandom});
            src_gaps_on  = (s != 2);
            sink_gaps_on = (s != 1);
            repeat (130) send_item(rand_item());
            wait_drained();
        end
    endtask

    // Result side holds off while words keep coming, so the pipe fills
    task automatic test_output_hold_off();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        hold_req     = 1'b1;
        repeat (80) send_item(rand_item());
        wait_drained();
    endtask

    // Sender stops mid-stream until every result is back
    task automatic test_drain_pause();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        repeat (30) send_item(rand_item());
        wait_drained();
        repeat (30) send_item(rand_item());
        wait_drained();
    endtask

    // Closing stretch at full rate, no gaps on either side
    task automatic test_full_rate();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        repeat (100) send_item(rand_item());
        wait_drained();
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_planes();
        test_spare_index();
        test_directed_frustum();
        test_extreme_planes();
        test_random_frusta();
        test_output_hold_off();
        test_drain_pause();
        test_full_rate();

        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (pending_verdicts.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_verdicts.size()));
        $display("Checked %0d box and %0d sphere words: %0d visible, %0d culled.",
                 n_box, n_sphere, n_visible, n_culled);
        $display("Plane settings used: %0d, plus spare index writes; %0d mismatches.",
                 n_settings, err_count);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
